>>> rtl/core/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Slot table geometry, request and result structs, codes and FSM states.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Table geometry
  localparam int NUM_SLOTS  = 64;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int TASK_ID_W  = 6;
  localparam int SLICE_W    = 8;

  // Slice given to slot 0 at reset
  localparam logic [SLICE_W-1:0] INIT_SLICE = SLICE_W'(2);

  typedef enum logic [1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_RUN    = 2'd1,
    ACT_SLEEP  = 2'd2,
    ACT_SWITCH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SLOT   = 2'd1,
    STAT_NO_EFFECT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_ALLOC = 2'd1,
    SLOT_RUN   = 2'd2
  } slot_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC_SCAN,
    ST_RUN_RD,
    ST_SW_LIST,
    ST_SW_SLOT,
    ST_SLP_RD,
    ST_SLP_SCAN,
    ST_SLP_END,
    ST_SLP_JMP,
    ST_RESP
  } fsm_state_t;

  typedef struct packed {
    action_t                action;
    logic [TASK_ID_W-1:0]   task_id;
    logic [SLICE_W-1:0]     priority_req;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [TASK_ID_W-1:0]   task_id_res;
    logic [SLICE_W-1:0]     slice;
    logic                   jump;
  } res_t;

  // One slot table entry
  typedef struct packed {
    slot_state_t            st;
    logic [SLICE_W-1:0]     slice;
  } slot_ent_t;

endpackage

>>> rtl/core/round_robin_task_scheduler.sv
// Each request ends in a response state that loads the result into the output
//   register once that register is free.
// Throughput: one request at a time; allocate walks the slot table and sleep
//   walks the run list, one entry per cycle through a single memory read port.
// Reset: synchronous, active low. Table entries carry valid bits, so the
//   block takes requests in the first cycle after reset with no clearing pass.
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler over a slot table and a compacted run list, both
// kept in single-port-read synchronous memories with read-modify-write.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrts_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output rrts_pkg::res_t out_res
);

  localparam int SW = rrts_pkg::SLOT_W;
  localparam int CW = rrts_pkg::CNT_W;

  // Slot table memory and its valid bits
  rrts_pkg::slot_ent_t            slot_mem [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::NUM_SLOTS-1:0] slot_vld_r;
  logic                           slot_rd_en;
  logic [SW-1:0]                  slot_rd_addr;
  logic                           slot_we;
  logic [SW-1:0]                  slot_wr_addr;
  rrts_pkg::slot_ent_t            slot_wr_data;
  rrts_pkg::slot_ent_t            slot_q_r;
  logic                           slot_q_vld_r;
  logic                           slot_q_zero_r;
  rrts_pkg::slot_ent_t            slot_q;

  // Run list memory
  logic [SW-1:0]                  rl_mem [rrts_pkg::NUM_SLOTS];
  logic                           rl_rd_en;
  logic [SW-1:0]                  rl_rd_addr;
  logic                           rl_we;
  logic [SW-1:0]                  rl_wr_addr;
  logic [SW-1:0]                  rl_wr_data;
  logic [SW-1:0]                  rl_q_r;
  logic                           rl_q_clr_r;
  logic                           rl0_wr_r;
  logic [SW-1:0]                  rl_q;

  // Control state
  rrts_pkg::fsm_state_t state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [SW-1:0]        cur_r, cur_nxt;
  logic [SW-1:0]        idx_r, idx_nxt;
  logic [SW-1:0]        pos_r, pos_nxt;
  logic [SW-1:0]        id_r, id_nxt;
  logic [rrts_pkg::SLICE_W-1:0] prio_r, prio_nxt;
  logic                 found_r, found_nxt;
  logic                 hit_cur_r, hit_cur_nxt;
  rrts_pkg::res_t       res_r, res_nxt;
  logic                 out_valid_r;
  rrts_pkg::res_t       out_res_r;
  logic                 out_load;

  // Scratch values of the next-state logic
  logic [CW-1:0]        cur_inc;
  logic [CW-1:0]        cnt_n;
  logic [SW-1:0]        cur_a;
  logic [SW-1:0]        cur_b;
  logic                 append;
  logic                 rl_hit;

  // Slot table: one write, one registered read
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wr_addr] <= slot_wr_data;
    end
    if (slot_rd_en) begin
      slot_q_r      <= slot_mem[slot_rd_addr];
      slot_q_vld_r  <= slot_vld_r[slot_rd_addr];
      slot_q_zero_r <= (slot_rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (slot_we) begin
      slot_vld_r[slot_wr_addr] <= 1'b1;
    end
  end

  // Never-written entries read as their reset value
  always_comb begin
    if (slot_q_vld_r) begin
      slot_q = slot_q_r;
    end else if (slot_q_zero_r) begin
      slot_q = '{st: rrts_pkg::SLOT_RUN, slice: rrts_pkg::INIT_SLICE};
    end else begin
      slot_q = '{st: rrts_pkg::SLOT_FREE, slice: '0};
    end
  end

  // Run list: one write, one registered read
  always_ff @(posedge clk) begin
    if (rl_we) begin
      rl_mem[rl_wr_addr] <= rl_wr_data;
    end
    if (rl_rd_en) begin
      rl_q_r     <= rl_mem[rl_rd_addr];
      rl_q_clr_r <= (rl_rd_addr == '0) && !rl0_wr_r;
    end
  end

  // Entry 0 holds slot 0 until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rl0_wr_r <= 1'b0;
    end else if (rl_we && (rl_wr_addr == '0)) begin
      rl0_wr_r <= 1'b1;
    end
  end

  assign rl_q = rl_q_clr_r ? '0 : rl_q_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrts_pkg::ST_IDLE;
      count_r   <= CW'(1);
      cur_r     <= '0;
      found_r   <= 1'b0;
      hit_cur_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cur_r     <= cur_nxt;
      found_r   <= found_nxt;
      hit_cur_r <= hit_cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
    res_r  <= res_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
    end
  end

  assign in_ready  = (state_r == rrts_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Next state, memory accesses and result
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    id_nxt       = id_r;
    prio_nxt     = prio_r;
    found_nxt    = found_r;
    hit_cur_nxt  = hit_cur_r;
    res_nxt      = res_r;
    out_load     = 1'b0;
    slot_rd_en   = 1'b0;
    slot_rd_addr = '0;
    slot_we      = 1'b0;
    slot_wr_addr = id_r;
    slot_wr_data = slot_q;
    rl_rd_en     = 1'b0;
    rl_rd_addr   = '0;
    rl_we        = 1'b0;
    rl_wr_addr   = '0;
    rl_wr_data   = id_r;
    cur_inc      = CW'(cur_r) + CW'(1);
    cnt_n        = found_r ? (count_r - CW'(1)) : count_r;
    cur_a        = (found_r && (pos_r < cur_r)) ? (cur_r - SW'(1)) : cur_r;
    cur_b        = (CW'(cur_a) >= cnt_n) ? '0 : cur_a;
    append       = (slot_q.st != rrts_pkg::SLOT_RUN) &&
                   (count_r < CW'(rrts_pkg::NUM_SLOTS));
    rl_hit       = (rl_q == id_r);

    unique case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (in_valid) begin
          id_nxt   = SW'(in_req.task_id);
          prio_nxt = in_req.priority_req;
          res_nxt  = '{status: rrts_pkg::STAT_NO_EFFECT, task_id_res: '0,
                       slice: '0, jump: 1'b0};
          unique case (in_req.action)
            rrts_pkg::ACT_ALLOC: begin
              slot_rd_en   = 1'b1;
              slot_rd_addr = '0;
              idx_nxt      = '0;
              state_nxt    = rrts_pkg::ST_ALLOC_SCAN;
            end
            rrts_pkg::ACT_RUN: begin
              if (int'(in_req.task_id) >= rrts_pkg::NUM_SLOTS) begin
                state_nxt = rrts_pkg::ST_RESP;
              end else begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = SW'(in_req.task_id);
                state_nxt    = rrts_pkg::ST_RUN_RD;
              end
            end
            rrts_pkg::ACT_SLEEP: begin
              if (int'(in_req.task_id) >= rrts_pkg::NUM_SLOTS) begin
                state_nxt = rrts_pkg::ST_RESP;
              end else begin
                slot_rd_en   = 1'b1;
                slot_rd_addr = SW'(in_req.task_id);
                state_nxt    = rrts_pkg::ST_SLP_RD;
              end
            end
            rrts_pkg::ACT_SWITCH: begin
              if (count_r == '0) begin
                state_nxt = rrts_pkg::ST_RESP;
              end else begin
                cur_nxt    = (cur_inc >= count_r) ? '0 : SW'(cur_inc);
                rl_rd_en   = 1'b1;
                rl_rd_addr = (cur_inc >= count_r) ? '0 : SW'(cur_inc);
                state_nxt  = rrts_pkg::ST_SW_LIST;
              end
            end
            default: state_nxt = rrts_pkg::ST_IDLE;
          endcase
        end
      end

      // Pipelined search for the lowest free slot
      rrts_pkg::ST_ALLOC_SCAN: begin
        if (slot_q.st == rrts_pkg::SLOT_FREE) begin
          slot_we      = 1'b1;
          slot_wr_addr = idx_r;
          slot_wr_data = '{st: rrts_pkg::SLOT_ALLOC, slice: slot_q.slice};
          res_nxt      = '{status: rrts_pkg::STAT_OK,
                           task_id_res: rrts_pkg::TASK_ID_W'(idx_r),
                           slice: '0, jump: 1'b0};
          state_nxt    = rrts_pkg::ST_RESP;
        end else if (idx_r == SW'(rrts_pkg::NUM_SLOTS - 1)) begin
          res_nxt   = '{status: rrts_pkg::STAT_NO_SLOT, task_id_res: '0,
                        slice: '0, jump: 1'b0};
          state_nxt = rrts_pkg::ST_RESP;
        end else begin
          slot_rd_en   = 1'b1;
          slot_rd_addr = idx_r + SW'(1);
          idx_nxt      = idx_r + SW'(1);
        end
      end

      // Update slice if one is given, append to the run list if not yet runnable and not full
      rrts_pkg::ST_RUN_RD: begin
        slot_we      = 1'b1;
        slot_wr_addr = id_r;
        slot_wr_data = '{st: append ? rrts_pkg::SLOT_RUN : slot_q.st,
                         slice: (prio_r != '0) ? prio_r : slot_q.slice};
        if (append) begin
          rl_we      = 1'b1;
          rl_wr_addr = SW'(count_r);
          rl_wr_data = id_r;
          count_nxt  = count_r + CW'(1);
        end
        res_nxt   = '{status: ((prio_r != '0) || append) ? rrts_pkg::STAT_OK
                                                        : rrts_pkg::STAT_NO_EFFECT,
                      task_id_res: '0, slice: '0, jump: 1'b0};
        state_nxt = rrts_pkg::ST_RESP;
      end

      // Switch: fetch the selected task, then its slice
      rrts_pkg::ST_SW_LIST: begin
        id_nxt       = rl_q;
        slot_rd_en   = 1'b1;
        slot_rd_addr = rl_q;
        state_nxt    = rrts_pkg::ST_SW_SLOT;
      end

      rrts_pkg::ST_SW_SLOT: begin
        res_nxt   = '{status: rrts_pkg::STAT_OK,
                      task_id_res: rrts_pkg::TASK_ID_W'(id_r),
                      slice: slot_q.slice, jump: (count_r >= CW'(2))};
        state_nxt = rrts_pkg::ST_RESP;
      end

      // Sleep: check the slot, then walk the run list
      rrts_pkg::ST_SLP_RD: begin
        if ((slot_q.st != rrts_pkg::SLOT_RUN) || (count_r == '0)) begin
          state_nxt = rrts_pkg::ST_RESP;
        end else begin
          slot_we      = 1'b1;
          slot_wr_addr = id_r;
          slot_wr_data = '{st: rrts_pkg::SLOT_ALLOC, slice: slot_q.slice};
          rl_rd_en     = 1'b1;
          rl_rd_addr   = '0;
          idx_nxt      = '0;
          found_nxt    = 1'b0;
          hit_cur_nxt  = 1'b0;
          state_nxt    = rrts_pkg::ST_SLP_SCAN;
        end
      end

      // Find the task and shift later entries down by one
      rrts_pkg::ST_SLP_SCAN: begin
        if (rl_hit && (idx_r == cur_r)) begin
          hit_cur_nxt = 1'b1;
        end
        if (found_r) begin
          rl_we      = 1'b1;
          rl_wr_addr = idx_r - SW'(1);
          rl_wr_data = rl_q;
        end else if (rl_hit) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if ((CW'(idx_r) + CW'(1)) == count_r) begin
          state_nxt = rrts_pkg::ST_SLP_END;
        end else begin
          rl_rd_en   = 1'b1;
          rl_rd_addr = idx_r + SW'(1);
          idx_nxt    = idx_r + SW'(1);
        end
      end

      // Shrink the list, fix the current index, fetch the new current task if it was the sleeper
      rrts_pkg::ST_SLP_END: begin
        count_nxt = cnt_n;
        res_nxt   = '{status: rrts_pkg::STAT_OK, task_id_res: '0,
                      slice: '0, jump: 1'b0};
        if (hit_cur_r) begin
          cur_nxt = cur_b;
          if (cnt_n != '0) begin
            rl_rd_en   = 1'b1;
            rl_rd_addr = cur_b;
            state_nxt  = rrts_pkg::ST_SLP_JMP;
          end else begin
            state_nxt = rrts_pkg::ST_RESP;
          end
        end else begin
          cur_nxt   = cur_a;
          state_nxt = rrts_pkg::ST_RESP;
        end
      end

      rrts_pkg::ST_SLP_JMP: begin
        res_nxt   = '{status: rrts_pkg::STAT_OK,
                      task_id_res: rrts_pkg::TASK_ID_W'(rl_q),
                      slice: '0, jump: 1'b1};
        state_nxt = rrts_pkg::ST_RESP;
      end

      // Hand the result to the output register when it is free
      rrts_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = rrts_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rrts_pkg::ST_IDLE;
    endcase
  end

  // Run count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(rrts_pkg::NUM_SLOTS))
    else $error("run count above table size");

  // Current index points inside a non-empty run list between requests
  a_cur_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrts_pkg::ST_IDLE) && (count_r != '0) |-> (CW'(cur_r) < count_r))
    else $error("current index outside run list");

  // An accepted request always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r != rrts_pkg::ST_IDLE))
    else $error("request accepted without starting work");

  // Leaving the response state always fills the output register
  a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrts_pkg::ST_RESP) && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("result lost on the way to the output register");

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of round_robin_task_scheduler
// Drives allocate, run, sleep and switch requests through the valid/ready
// channel. A mirror of the slot table and run list predicts every result,
// and each returned result is compared field by field in order. The run
// covers directed corner cases, random phases under sender and receiver
// stalls, slot exhaustion, and a full fill and drain of the run list.
// ----------------------------------------------------------------------------
module tb;
  import rrts_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int TAIL_CYCLES  = NUM_SLOTS + 8;
  localparam int TIMEOUT_NS   = 10_000_000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  req_t in_req    = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  res_t out_res;

  // Stall knobs, in percent
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Run statistics
  int n_errors    = 0;
  int n_requests  = 0;
  int n_checked   = 0;
  int n_jumps     = 0;
  int n_no_slot   = 0;
  int n_no_effect = 0;
  int peak_run    = 0;

  // Mirror of the scheduler state
  slot_state_t          sl_state [NUM_SLOTS];
  logic [SLICE_W-1:0]   sl_slice [NUM_SLOTS];
  logic [TASK_ID_W-1:0] rq_list  [NUM_SLOTS];
  int                   rq_count;
  int                   rq_cur;

  // Results predicted but not yet returned, oldest first
  res_t due_results[$];

  round_robin_task_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic mirror_reset();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sl_state[i] = SLOT_FREE;
      sl_slice[i] = '0;
      rq_list[i]  = '0;
    end
    sl_state[0] = SLOT_RUN;
    sl_slice[0] = INIT_SLICE;
    rq_count    = 1;
    rq_cur      = 0;
  endtask

  // Applies one request to the mirror and returns the result it must give
  function automatic res_t schedule_step(req_t r);
    res_t res;
    int   id;
    int   idx;
    int   sel;
    bit   changed;
    bit   was_cur;
    res        = '0;
    res.status = STAT_OK;
    id         = int'(r.task_id);
    if (r.action == ACT_ALLOC) begin
      res.status = STAT_NO_SLOT;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (sl_state[i] == SLOT_FREE) begin
          sl_state[i]     = SLOT_ALLOC;
          res.status      = STAT_OK;
          res.task_id_res = TASK_ID_W'(i);
          break;
        end
      end
    end else if (r.action == ACT_SWITCH) begin
      if (rq_count == 0) begin
        res.status = STAT_NO_EFFECT;
      end else begin
        rq_cur++;
        if (rq_cur >= rq_count) rq_cur = 0;
        sel             = int'(rq_list[rq_cur]);
        res.task_id_res = TASK_ID_W'(sel);
        res.slice       = sl_slice[sel];
        res.jump        = (rq_count >= 2);
      end
    end else if (id >= NUM_SLOTS) begin
      res.status = STAT_NO_EFFECT;
    end else if (r.action == ACT_RUN) begin
      changed = 1'b0;
      if (r.priority_req != '0) begin
        sl_slice[id] = r.priority_req;
        changed      = 1'b1;
      end
      if (sl_state[id] != SLOT_RUN && rq_count < NUM_SLOTS) begin
        sl_state[id]      = SLOT_RUN;
        rq_list[rq_count] = TASK_ID_W'(id);
        rq_count++;
        changed = 1'b1;
      end
      res.status = changed ? STAT_OK : STAT_NO_EFFECT;
    end else if (sl_state[id] != SLOT_RUN || rq_count == 0) begin
      // sleep of a task that is not runnable
      res.status = STAT_NO_EFFECT;
    end else begin
      // sleep: drop the task from the list and close the gap
      was_cur = (rq_cur < rq_count) && (int'(rq_list[rq_cur]) == id);
      idx = 0;
      while (idx < rq_count && int'(rq_list[idx]) != id) idx++;
      if (idx < rq_count) begin
        rq_count--;
        if (idx < rq_cur) rq_cur--;
        for (int j = idx; j < rq_count; j++) rq_list[j] = rq_list[j+1];
      end
      sl_state[id] = SLOT_ALLOC;
      if (was_cur) begin
        if (rq_cur >= rq_count) rq_cur = 0;
        if (rq_count > 0) begin
          res.task_id_res = rq_list[rq_cur];
          res.jump        = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // Sends one request, then records its predicted result once accepted
  task automatic send_request(action_t act, logic [TASK_ID_W-1:0] id,
                              logic [SLICE_W-1:0] prio);
    req_t r;
    res_t want;
    r.action       = act;
    r.task_id      = id;
    r.priority_req = prio;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    want = schedule_step(r);
    n_requests++;
    if (want.jump) n_jumps++;
    if (want.status == STAT_NO_SLOT) n_no_slot++;
    if (want.status == STAT_NO_EFFECT) n_no_effect++;
    if (rq_count > peak_run) peak_run = rq_count;
    due_results.push_back(want);
  endtask

  // Holds the sender off until every outstanding result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(string field, logic [7:0] want_v, logic [7:0] got_v);
    if (got_v !== want_v) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_checked++;
      if (due_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected, status=%0d id=%0d slice=%0d jump=%0d",
                 $time, out_res.status, out_res.task_id_res, out_res.slice, out_res.jump);
      end else begin
        want = due_results.pop_front();
        report_field("status", 8'(want.status), 8'(out_res.status));
        report_field("task_id_res", 8'(want.task_id_res), 8'(out_res.task_id_res));
        report_field("slice", want.slice, out_res.slice);
        report_field("jump", 8'(want.jump), 8'(out_res.jump));
      end
    end
  end

  // Corner cases walked in a fixed order from the reset state
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(ACT_SWITCH, 6'd0,  8'd0);    // single task: no jump
    send_request(ACT_ALLOC,  6'd63, 8'd255);  // lowest free slot
    send_request(ACT_RUN,    6'd1,  8'd0);    // allocated slot becomes runnable
    send_request(ACT_RUN,    6'd1,  8'd0);    // already runnable, no change
    send_request(ACT_RUN,    6'd1,  8'd255);  // slice update only
    send_request(ACT_SWITCH, 6'd0,  8'd0);
    send_request(ACT_SWITCH, 6'd63, 8'd0);    // wraps back to the head
    send_request(ACT_RUN,    6'd63, 8'd1);    // free slot runs all the same
    send_request(ACT_SLEEP,  6'd5,  8'd0);    // free slot
    send_request(ACT_ALLOC,  6'd0,  8'd0);
    send_request(ACT_SLEEP,  6'd2,  8'd128);  // allocated, not runnable
    send_request(ACT_SWITCH, 6'd0,  8'd0);
    send_request(ACT_SWITCH, 6'd0,  8'd0);
    send_request(ACT_SLEEP,  6'd63, 8'd0);    // current at tail: index wraps
    send_request(ACT_SLEEP,  6'd1,  8'd0);    // not current
    send_request(ACT_SLEEP,  6'd0,  8'd0);    // last task: list goes empty
    send_request(ACT_SWITCH, 6'd0,  8'd0);    // empty list
    send_request(ACT_SLEEP,  6'd0,  8'd0);    // empty list
    send_request(ACT_RUN,    6'd0,  8'd0);    // stored slice kept
    send_request(ACT_SWITCH, 6'd0,  8'd0);
    send_request(ACT_RUN,    6'd42, 8'd128);
    send_request(ACT_RUN,    6'd2,  8'd127);
    send_request(ACT_SWITCH, 6'd63, 8'd255);
    send_request(ACT_SLEEP,  6'd42, 8'd0);    // current in the middle
  endtask

  // Random requests steered toward a run list size that drifts over time
  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    int target;
    int pick;
    int roll;
    bit grow;
    logic [TASK_ID_W-1:0] id;
    logic [SLICE_W-1:0]   prio;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = 1;
    for (int k = 0; k < n_items; k++) begin
      if (k % 64 == 0) target = $urandom_range(NUM_SLOTS);
      pick = $urandom_range(99);
      roll = $urandom_range(99);
      id   = TASK_ID_W'($urandom_range(NUM_SLOTS - 1));
      prio = SLICE_W'($urandom_range(255));
      grow = (rq_count < target);
      if (pick < 5) begin
        send_request(ACT_ALLOC, id, prio);
      end else if (pick < 35) begin
        send_request(ACT_SWITCH, id, prio);
      end else if ((grow && roll < 75) || (!grow && roll < 25)) begin
        if (rq_count > 0 && $urandom_range(99) < 30)
          id = rq_list[$urandom_range(rq_count - 1)];
        if ($urandom_range(99) < 35) prio = '0;
        send_request(ACT_RUN, id, prio);
      end else begin
        roll = $urandom_range(99);
        if (rq_count > 0 && roll < 50)
          id = rq_list[$urandom_range(rq_count - 1)];
        else if (rq_count > 0 && rq_cur < rq_count && roll < 75)
          id = rq_list[rq_cur];
        send_request(ACT_SLEEP, id, prio);
      end
    end
  endtask

  // Allocates until the slot table runs dry
  task automatic test_alloc_exhaust();
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    for (int k = 0; k < NUM_SLOTS + 4; k++)
      send_request(ACT_ALLOC, TASK_ID_W'($urandom_range(NUM_SLOTS - 1)),
                   SLICE_W'($urandom_range(255)));
  endtask

  // Makes every slot runnable, cycles the full list, then sleeps them all
  task automatic test_fill_and_drain();
    int order[NUM_SLOTS];
    int j;
    int tmp;
    send_idle_pct  = 8;
    recv_stall_pct = 8;
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(ACT_RUN, TASK_ID_W'(order[i]), SLICE_W'($urandom_range(255)));
    for (int i = 0; i < NUM_SLOTS + 6; i++)
      send_request(ACT_SWITCH, '0, '0);
    send_request(ACT_RUN, TASK_ID_W'(order[0]), '0);
    send_request(ACT_ALLOC, '0, '0);
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      send_request(ACT_SLEEP, TASK_ID_W'(order[i]), '0);
      if (i % 3 == 0) send_request(ACT_SWITCH, '0, '0);
    end
    send_request(ACT_SWITCH, '0, '0);
  endtask

  initial begin
    mirror_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_idle();
    test_random(180, 0, 0);
    wait_idle();
    test_random(180, 72, 0);
    wait_idle();
    test_random(180, 0, 72);
    wait_idle();
    test_random(195, 8, 8);
    wait_idle();
    test_alloc_exhaust();
    test_fill_and_drain();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d task switches, %0d full-table",
             n_requests, n_checked, n_jumps, n_no_slot);
    $display("allocations, %0d requests with no effect; run list peaked at %0d of %0d slots",
             n_no_effect, peak_run, NUM_SLOTS);
    if (n_errors == 0) begin
      $display("PASS round_robin_task_scheduler");
    end else begin
      $display("FAIL round_robin_task_scheduler");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", due_results.size());
    $display("FAIL round_robin_task_scheduler");
    $finish;
  end

endmodule

>>> round_robin_task_scheduler.f
rtl/core/rrts_pkg.sv
rtl/core/round_robin_task_scheduler.sv
dv/tb.sv
